// ----- sv/mf3_pkg.sv -----
// Package for the 3x3 gray median filter: pixel, column and window types,
// register indexes, conversion weights and small compare-select functions.
// No dependencies.
package mf3_pkg;

	localparam int PIX_W      = 8;
	localparam int POS_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int MIN_SIZE   = 3;
	localparam int MAX_HEIGHT = 1024;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Luma weights in unsigned Q0.8; they sum to 256.
	localparam logic [7:0] W_BLUE  = 8'd29;
	localparam logic [7:0] W_GREEN = 8'd150;
	localparam logic [7:0] W_RED   = 8'd77;

	typedef logic [PIX_W-1:0] pix_t;

	// One window column, or the same three values in ascending order.
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col3_t;

	// Low, middle and high candidates for the final median.
	typedef struct packed {
		pix_t lo;
		pix_t mi;
		pix_t hi;
	} trio_t;

	// Position data that travels with a result item.
	typedef struct packed {
		logic [POS_W-1:0] center_col;
		logic [POS_W-1:0] center_row;
		logic             frame_end;
	} meta_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// Sorts three values: top is the smallest, bot the largest.
	function automatic col3_t sort3(input col3_t c);
		col3_t s;
		s.top = min2(min2(c.top, c.mid), c.bot);
		s.mid = med3(c.top, c.mid, c.bot);
		s.bot = max2(max2(c.top, c.mid), c.bot);
		return s;
	endfunction

endpackage

// ----- sv/median_filter_3x3_gray.sv -----
// Top level of the streaming 3x3 gray median filter.
// Depends on mf3_pkg, mf3_ram, mf3_cell and mf3_median.
//
// Streaming 3x3 median filter on the gray level of RGB pixels. Pixels enter in
// raster order, one item per clock cycle at full rate while results are taken,
// starting at column 0 of row 0 after reset. Each pixel is turned into gray as
// (29*blue + 150*green + 77*red) >> 8. For every interior centre a result item
// leaves with the median of its nine gray neighbours, the centre's column and row,
// and frame_end set on the last centre of the frame; border pixels produce no
// result item. Each window passes stage 1, the window cells and stage 3 to the
// output register. The rate of one item per cycle is set by the line memory, read
// once at acceptance and written once as the item leaves stage 1, on separate
// ports. Each of the four pipeline stages holds an item of its own, so the input
// keeps taking items while a result waits on the output, until the stages fill.
// The user writes image_width (clamped to 3..MAX_WIDTH) and image_height (clamped
// to 3..1024) through the configuration port only while the block is idle, which
// the block does not enforce; the line memory needs no clearing after reset.

module median_filter_3x3_gray #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mf3_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]      cfg_data,

	input  logic                                pix_valid,
	output logic                                pix_ready,
	input  logic [7:0]                          blue,
	input  logic [7:0]                          green,
	input  logic [7:0]                          red,

	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [7:0]                          median_value,
	output logic [mf3_pkg::POS_W-1:0]           center_col,
	output logic [mf3_pkg::POS_W-1:0]           center_row,
	output logic                                frame_end
);

	import mf3_pkg::*;

	// Column counter width, and a compare width that also holds the width register.
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int XW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
	localparam int WIDTH_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

	// Configuration: sizes are stored already clamped.
	logic [XW-1:0]         width_q;
	logic [CFG_DATA_W-1:0] height_q;
	logic [XW-1:0]         width_clamped;
	logic [CFG_DATA_W-1:0] height_clamped;

	// Raster position of the next pixel.
	logic [CW-1:0]    col_q;
	logic [POS_W-1:0] row_q;

	// Pipeline stages and their handshake.
	logic v1_q, v2_q, v3_q, v4_q;
	logic en1, en2, en3, en4;
	logic accept, move1;

	pix_t    gray_s1;
	logic    emit_s1;
	meta_t   meta_s1, meta_s2, meta_s3, meta_s4;
	logic [CW-1:0] col_s1;
	trio_t   trio_s3;
	pix_t    median_s4;

	logic [15:0] gray_sum;
	logic        emit_now;
	meta_t       meta_now;
	logic [XW-1:0] col_next;

	// Line memory: upper byte is the row before last, lower byte the previous row.
	logic [2*PIX_W-1:0] line_rd;
	logic [2*PIX_W-1:0] line_wr;

	col3_t new_col;
	col3_t cell_chain [4];
	col3_t cell_sorted [3];
	trio_t trio_now;

	// ---------------- Configuration port ----------------
	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data < CFG_DATA_W'(MIN_SIZE)) begin
			width_clamped = XW'(MIN_SIZE);
		end else if (XW'(cfg_data) > XW'(MAX_WIDTH)) begin
			width_clamped = XW'(MAX_WIDTH);
		end else begin
			width_clamped = XW'(cfg_data);
		end
		if (cfg_data < CFG_DATA_W'(MIN_SIZE)) begin
			height_clamped = CFG_DATA_W'(MIN_SIZE);
		end else if (cfg_data > CFG_DATA_W'(MAX_HEIGHT)) begin
			height_clamped = CFG_DATA_W'(MAX_HEIGHT);
		end else begin
			height_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= XW'(WIDTH_RESET);
			height_q <= CFG_DATA_W'(MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= width_clamped;
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= height_clamped;
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- Stage enables ----------------
	// A stage may load when it is empty or when its contents move on in the
	// same cycle. Stage 2 is the window itself, so it only counts as full while
	// it holds a window that still has to yield a result.
	assign en4       = !v4_q || res_ready;
	assign en3       = !v3_q || en4;
	assign en2       = !v2_q || en3;
	assign en1       = !v1_q || en2;
	assign pix_ready = en1;
	assign accept    = pix_valid && en1;
	assign move1     = v1_q && en2;

	// ---------------- Acceptance: gray, position and line read ----------------
	assign gray_sum = 16'(W_BLUE) * 16'(blue) + 16'(W_GREEN) * 16'(green)
		+ 16'(W_RED) * 16'(red);

	assign col_next = XW'(col_q) + XW'(1);

	always_comb begin
		emit_now = (col_q >= CW'(2)) && (row_q >= POS_W'(2))
			&& (XW'(col_q) < width_q) && (CFG_DATA_W'(row_q) < height_q);
		meta_now.center_col = POS_W'(col_q - CW'(1));
		meta_now.center_row = row_q - POS_W'(1);
		meta_now.frame_end  = (XW'(col_q) == width_q - XW'(1))
			&& (CFG_DATA_W'(row_q) == height_q - CFG_DATA_W'(1));
	end

	// The counters wrap at the current limits; a column counter left beyond a width
	// that shrank wraps at the next pixel, a row counter at the next line end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_next >= width_q) begin
				col_q <= '0;
				if (CFG_DATA_W'(row_q) + CFG_DATA_W'(1) >= height_q) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + POS_W'(1);
				end
			end else begin
				col_q <= CW'(col_next);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (en1) begin
			v1_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1 <= gray_sum[15:8];
			emit_s1 <= emit_now;
			meta_s1 <= meta_now;
			col_s1  <= col_q;
		end
	end

	// The read is issued at acceptance; its data stays put until the next
	// acceptance, which cannot happen before stage 1 has moved on.
	assign line_wr = {line_rd[PIX_W-1:0], gray_s1};

	mf3_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (move1),
		.waddr(col_s1),
		.wdata(line_wr),
		.re   (accept),
		.raddr(col_q),
		.rdata(line_rd)
	);

	// ---------------- Stage 2: window of three column cells ----------------
	// The newest column enters cell 0; each shift hands every column to the
	// next cell, and the oldest one drops out of cell 2.
	assign new_col.top = line_rd[2*PIX_W-1:PIX_W];
	assign new_col.mid = line_rd[PIX_W-1:0];
	assign new_col.bot = gray_s1;
	assign cell_chain[0] = new_col;

	for (genvar i = 0; i < 3; i++) begin : g_cell
		mf3_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (move1),
			.col_in    (cell_chain[i]),
			.col_out   (cell_chain[i+1]),
			.col_sorted(cell_sorted[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (en2) begin
			v2_q <= v1_q && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move1) begin
			meta_s2 <= meta_s1;
		end
	end

	// ---------------- Stage 3: median candidates ----------------
	mf3_median u_median (
		.col_a(cell_sorted[0]),
		.col_b(cell_sorted[1]),
		.col_c(cell_sorted[2]),
		.trio (trio_now)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
		end else if (en3) begin
			v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v2_q) begin
			trio_s3 <= trio_now;
			meta_s3 <= meta_s2;
		end
	end

	// ---------------- Stage 4: output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_q <= 1'b0;
		end else if (en4) begin
			v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v3_q) begin
			median_s4 <= med3(trio_s3.lo, trio_s3.mi, trio_s3.hi);
			meta_s4   <= meta_s3;
		end
	end

	assign res_valid    = v4_q;
	assign median_value = median_s4;
	assign center_col   = meta_s4.center_col;
	assign center_row   = meta_s4.center_row;
	assign frame_end    = meta_s4.frame_end;

	// ---------------- Assertions ----------------
	// The line memory is never written and read at the same entry in one cycle.
	a_line_ports_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(move1 && accept) |-> (col_s1 != col_q))
		else $error("line memory read and write hit the same entry");

	// The column counter always addresses an existing line memory entry.
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(col_q) < XW'(MAX_WIDTH))
		else $error("column counter beyond the line memory");

	// A window only shifts when stage 1 holds an item and the window is free.
	a_window_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && !en3) |=> $stable(cell_chain[1]))
		else $error("window changed under a pending result");

endmodule

// ----- sv/mf3_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mf3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/mf3_cell.sv -----
// One column cell of the 3x3 window: holds a column, hands it to its neighbour
// on every shift and presents the column sorted. Depends on mf3_pkg.
module mf3_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  mf3_pkg::col3_t col_in,
	output mf3_pkg::col3_t col_out,
	output mf3_pkg::col3_t col_sorted
);

	import mf3_pkg::*;

	col3_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out    = col_q;
	assign col_sorted = sort3(col_q);

endmodule

// ----- sv/mf3_median.sv -----
// Reduces three sorted columns to the low, middle and high median candidates.
// Depends on mf3_pkg.
module mf3_median (
	input  mf3_pkg::col3_t col_a,
	input  mf3_pkg::col3_t col_b,
	input  mf3_pkg::col3_t col_c,
	output mf3_pkg::trio_t trio
);

	import mf3_pkg::*;

	// The median of nine is the median of the largest minimum, the median of the
	// medians and the smallest maximum of the sorted columns.
	always_comb begin
		trio.lo = max2(max2(col_a.top, col_b.top), col_c.top);
		trio.mi = med3(col_a.mid, col_b.mid, col_c.mid);
		trio.hi = min2(min2(col_a.bot, col_b.bot), col_c.bot);
	end

endmodule

// ----- tb/sv/median_filter_3x3_gray_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for median_filter_3x3_gray: streams RGB pixel items in raster
// order, predicts every 3x3 gray median with its position and checks each result item.
// Depends on mf3_pkg and the median_filter_3x3_gray RTL.

module median_filter_3x3_gray_tb;
	import mf3_pkg::*;

	localparam int     LINE_DEPTH    = 1024;
	localparam int     PIPE_LATENCY  = 4;
	localparam int     SETTLE_CYCLES = PIPE_LATENCY + 4;
	localparam int     MAX_IDLE      = 12;
	localparam int     LONG_HOLD     = 300;
	localparam int     RANDOM_PIXELS = 800;
	localparam int     N_DIRECTED    = 27;
	localparam longint CYCLE_LIMIT   = 1500000;

	// Index with no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

	// One result item as it leaves the block.
	typedef struct packed {
		pix_t             median_value;
		logic [POS_W-1:0] center_col;
		logic [POS_W-1:0] center_row;
		logic             frame_end;
	} median_result_t;

	// Travels with each pixel item from the driver to the acceptance monitor. When
	// typed is set, the hand-written result replaces the predicted one.
	typedef struct packed {
		logic           typed;
		median_result_t res;
	} pixel_note_t;

	// One row of the directed table. A row with set_size first waits for the block
	// to drain and then writes both size registers.
	typedef struct packed {
		logic                  set_size;
		logic [CFG_DATA_W-1:0] width_val;
		logic [CFG_DATA_W-1:0] height_val;
		pix_t                  blue_v;
		pix_t                  green_v;
		pix_t                  red_v;
		logic                  typed;
		pix_t                  med;
		logic [POS_W-1:0]      col;
		logic [POS_W-1:0]      row;
		logic                  fe;
	} directed_row_t;

	// Three 3x3 frames. The first is all white and the second all black but for a
	// white centre, so their medians are obvious; the first frame follows reset
	// directly. The second frame's sizes are below the minimum and clamp to 3x3. The
	// third mixes primaries and odd levels and is left to the predictor.
	localparam directed_row_t DIRECTED [N_DIRECTED] = '{
		'{1'b1, 11'd3, 11'd3, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 10'd1, 10'd1, 1'b1},
		'{1'b1, 11'd2, 11'd1, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 10'd1, 10'd1, 1'b1},
		'{1'b1, 11'd3, 11'd3, 8'd255, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd0, 8'd255, 8'd0, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd0, 8'd0, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd255, 8'd255, 8'd0, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd0, 8'd255, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd255, 8'd0, 8'd255, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd128, 8'd128, 8'd128, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd1, 8'd2, 8'd3, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0},
		'{1'b0, 11'd0, 11'd0, 8'd254, 8'd253, 8'd252, 1'b0, 8'd0, 10'd0, 10'd0, 1'b0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  pix_valid;
	logic                  pix_ready;
	logic [7:0]            blue;
	logic [7:0]            green;
	logic [7:0]            red;
	logic                  res_valid;
	logic                  res_ready;
	logic [7:0]            median_value;
	logic [POS_W-1:0]      center_col;
	logic [POS_W-1:0]      center_row;
	logic                  frame_end;

	// Predictor state: the two previous gray rows, the 3x3 window (column 0 oldest,
	// row 0 top, indexed col*3 + row), the raster position of the next pixel and the
	// size registers as written.
	pix_t                  row_above [LINE_DEPTH];
	pix_t                  row_above2 [LINE_DEPTH];
	pix_t                  gray_window [9];
	int                    pred_col;
	int                    pred_row;
	logic [CFG_DATA_W-1:0] width_setting;
	logic [CFG_DATA_W-1:0] height_setting;

	median_result_t        pending_medians [$];
	pixel_note_t           pixel_notes [$];

	int     errors;
	int     pixels_sent;
	int     results_seen;
	int     frame_ends_seen;
	int     cfg_writes;
	int     mid_frame_writes;
	int     long_holds;
	longint cycle_count;
	bit     sender_burst;
	bit     sink_burst;
	bit     hold_request;
	pix_t   phase_base;

	median_filter_3x3_gray u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.median_value (median_value),
		.center_col   (center_col),
		.center_row   (center_row),
		.frame_end    (frame_end)
	);

	always #1 clk = ~clk;

	// Sizes outside 3..limit are pulled to the nearest bound before use.
	function automatic int clamp_size(input logic [CFG_DATA_W-1:0] v, input int hi);
		if (v < MIN_SIZE) return MIN_SIZE;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	// Predicts one pixel item: converts it to gray, shifts it through the line rows
	// and the window, and returns 1 with the result when the window is interior.
	function automatic bit filter_pixel(input pix_t b, input pix_t g, input pix_t r,
			output median_result_t res);
		int   w;
		int   h;
		int   luma;
		int   i;
		int   j;
		pix_t gray;
		pix_t up1;
		pix_t up2;
		pix_t held;
		pix_t ranked [9];
		bit   produced;

		w = clamp_size(width_setting, LINE_DEPTH);
		h = clamp_size(height_setting, MAX_HEIGHT);
		luma = int'(W_BLUE) * int'(b) + int'(W_GREEN) * int'(g) + int'(W_RED) * int'(r);
		gray = pix_t'(luma >> 8);
		up1 = '0;
		up2 = '0;
		if (pred_col < LINE_DEPTH) begin
			up2 = row_above2[pred_col];
			up1 = row_above[pred_col];
			row_above2[pred_col] = up1;
			row_above[pred_col] = gray;
		end
		for (i = 0; i < 6; i++) gray_window[i] = gray_window[i + 3];
		gray_window[6] = up2;
		gray_window[7] = up1;
		gray_window[8] = gray;

		res = '0;
		produced = (pred_col >= 2 && pred_row >= 2 && pred_col < w && pred_row < h);
		if (produced) begin
			// Insertion sort of the nine values; the fifth is the median.
			for (i = 0; i < 9; i++) ranked[i] = gray_window[i];
			for (i = 1; i < 9; i++) begin
				held = ranked[i];
				j = i;
				while (j > 0 && ranked[j - 1] > held) begin
					ranked[j] = ranked[j - 1];
					j--;
				end
				ranked[j] = held;
			end
			res.median_value = ranked[4];
			res.center_col = POS_W'(pred_col - 1);
			res.center_row = POS_W'(pred_row - 1);
			res.frame_end = (pred_col == w - 1 && pred_row == h - 1);
		end

		if (pred_col + 1 >= w) begin
			pred_col = 0;
			pred_row = (pred_row + 1 >= h) ? 0 : pred_row + 1;
		end else begin
			pred_col++;
		end
		return produced;
	endfunction

	// Number of pixels that brings the raster position back to the frame start.
	function automatic int pixels_to_wrap();
		int w;
		int h;
		int x;
		int y;
		int n;

		w = clamp_size(width_setting, LINE_DEPTH);
		h = clamp_size(height_setting, MAX_HEIGHT);
		x = pred_col;
		y = pred_row;
		n = 0;
		do begin
			n++;
			if (x + 1 >= w) begin
				x = 0;
				y = (y + 1 >= h) ? 0 : y + 1;
			end else begin
				x++;
			end
		end while (x != 0 || y != 0);
		return n;
	endfunction

	// Half of the slots go without idling; in a burst stretch none idle at all.
	function automatic int draw_gap(input bit burst);
		if (burst || $urandom_range(0, 1) == 0) return 0;
		return $urandom_range(1, MAX_IDLE);
	endfunction

	// Colour levels lean towards the extremes and towards a level shared by the
	// phase, so that ties and flat neighbourhoods turn up in the windows.
	function automatic pix_t random_level();
		case ($urandom_range(0, 4))
			0: return 8'd0;
			1: return 8'd255;
			2: return phase_base + pix_t'($urandom_range(0, 7));
			default: return pix_t'($urandom);
		endcase
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// Register writes happen only when the block is idle, so they are applied to the
	// predictor at the edge where the write is taken.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Offers one pixel item after a random gap and returns at the edge where it is
	// taken. Valid stays high into the next item when no gap is drawn.
	task automatic send_pixel(input pix_t b, input pix_t g, input pix_t r,
			input pixel_note_t note);
		int gap;

		gap = draw_gap(sender_burst);
		if (gap > 0) begin
			@(negedge clk);
			pix_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pixel_notes.push_back(note);
		pix_valid = 1'b1;
		blue = b;
		green = g;
		red = r;
		do @(posedge clk); while (!pix_ready);
		pixels_sent++;
	endtask

	task automatic send_random_pixels(input int count);
		for (int k = 0; k < count; k++)
			send_pixel(random_level(), random_level(), random_level(), '0);
	endtask

	// Stops offering pixels, waits until every predicted result has been taken and
	// then lets the pipeline settle, since border pixels leave nothing to wait for.
	task automatic drain_results();
		@(negedge clk);
		pix_valid = 1'b0;
		while (pending_medians.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One random phase, always entered at the start of a frame: new sizes, then whole
	// frames. With cut_short the last frame is broken off, the width is narrowed (and
	// perhaps the height changed) while the counters sit mid-frame, and the frame is
	// run out under the new sizes. Narrowing only keeps every line entry that a
	// result can see written within the current frame.
	task automatic run_phase(input logic [CFG_DATA_W-1:0] w_val,
			input logic [CFG_DATA_W-1:0] h_val, input int n_frames, input bit cut_short);
		int per_frame;
		int n;

		drain_results();
		write_reg(REG_IMAGE_WIDTH, w_val);
		write_reg(REG_IMAGE_HEIGHT, h_val);
		phase_base = pix_t'($urandom);
		per_frame = pixels_to_wrap();
		n = per_frame * n_frames;
		if (!cut_short) begin
			send_random_pixels(n);
		end else begin
			send_random_pixels(n - $urandom_range(1, per_frame - 1));
			drain_results();
			write_reg(REG_IMAGE_WIDTH,
				CFG_DATA_W'($urandom_range(MIN_SIZE, clamp_size(w_val, LINE_DEPTH))));
			mid_frame_writes++;
			if ($urandom_range(0, 1) == 1) begin
				write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(MIN_SIZE, 8)));
				mid_frame_writes++;
			end
			send_random_pixels(pixels_to_wrap());
		end
	endtask

	// Acceptance monitor. Inputs change on the falling edge, so everything sampled
	// here on the rising edge is stable; the block's own updates at this edge are
	// not yet visible.
	always @(posedge clk) begin : monitor
		pixel_note_t    note;
		median_result_t predicted;
		median_result_t want;
		bit             produced;

		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				if (cfg_index == REG_IMAGE_WIDTH) width_setting = cfg_data;
				else if (cfg_index == REG_IMAGE_HEIGHT) height_setting = cfg_data;
			end
			if (pix_valid && pix_ready) begin
				note = pixel_notes.pop_front();
				produced = filter_pixel(blue, green, red, predicted);
				if (note.typed) pending_medians.push_back(note.res);
				else if (produced) pending_medians.push_back(predicted);
			end
			if (res_valid && res_ready) begin
				results_seen++;
				if (frame_end) frame_ends_seen++;
				if (pending_medians.size() == 0) begin
					errors++;
					$display("%0t ns: result item with none expected: median %0d at (%0d,%0d)",
						$time, median_value, center_col, center_row);
				end else begin
					want = pending_medians.pop_front();
					check_field("median_value", want.median_value, median_value);
					check_field("center_col", want.center_col, center_col);
					check_field("center_row", want.center_row, center_row);
					check_field("frame_end", want.frame_end, frame_end);
				end
			end
		end
	end

	// Watchdog: a correct run ends far below this bound.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycle_count, pending_medians.size());
			$display("median_filter_3x3_gray: mismatch");
			$finish;
		end
	end

	// Result receiver. Before every item it draws its own stall and now and then
	// switches between stretches with and without stalls. On request it holds ready
	// low for a long, counted stretch so that the pipeline backs up to the input.
	initial begin : result_sink
		int stall;

		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
			stall = draw_gap(sink_burst);
			if (hold_request) begin
				hold_request = 1'b0;
				stall = LONG_HOLD;
				long_holds++;
			end
			if (stall > 0) begin
				@(negedge clk);
				res_ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			res_ready = 1'b1;
			do @(posedge clk); while (!res_valid);
		end
	end

	initial begin : stimulus
		pixel_note_t note;
		int          phase;
		int          w_pick;
		int          h_pick;

		errors = 0;
		pixels_sent = 0;
		results_seen = 0;
		frame_ends_seen = 0;
		cfg_writes = 0;
		mid_frame_writes = 0;
		long_holds = 0;
		cycle_count = 0;
		sender_burst = 1'b0;
		sink_burst = 1'b0;
		hold_request = 1'b0;
		phase_base = '0;

		// The predictor starts from the reset state: full-size frame, empty window.
		width_setting = CFG_DATA_W'(LINE_DEPTH);
		height_setting = CFG_DATA_W'(MAX_HEIGHT);
		pred_col = 0;
		pred_row = 0;
		for (int k = 0; k < LINE_DEPTH; k++) begin
			row_above[k] = '0;
			row_above2[k] = '0;
		end
		for (int k = 0; k < 9; k++) gray_window[k] = '0;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_valid = 1'b0;
		blue = '0;
		green = '0;
		red = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: walk the table, hand-written results where the row has one.
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].set_size) begin
				drain_results();
				write_reg(REG_IMAGE_WIDTH, DIRECTED[i].width_val);
				write_reg(REG_IMAGE_HEIGHT, DIRECTED[i].height_val);
			end
			note.typed = DIRECTED[i].typed;
			note.res = '{DIRECTED[i].med, DIRECTED[i].col, DIRECTED[i].row, DIRECTED[i].fe};
			send_pixel(DIRECTED[i].blue_v, DIRECTED[i].green_v, DIRECTED[i].red_v, note);
		end

		// A write to an index with no register must leave the sizes alone.
		drain_results();
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));

		// Random part on small frames. Most widths are 3..12 with some wider lines and
		// some values below the minimum; heights stay short so results come often.
		phase = 0;
		while (pixels_sent < N_DIRECTED + RANDOM_PIXELS) begin
			if (phase == 2) begin
				// Back-pressure phase: the receiver holds off while the sender keeps
				// offering pixels with no gaps, so the block must stall its input.
				sender_burst = 1'b1;
				hold_request = 1'b1;
				run_phase(11'd10, 11'd6, 1, 1'b0);
			end else begin
				sender_burst = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 9))
					0: w_pick = $urandom_range(0, MIN_SIZE - 1);
					1, 2: w_pick = $urandom_range(13, 40);
					default: w_pick = $urandom_range(MIN_SIZE, 12);
				endcase
				h_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MIN_SIZE - 1)
					: $urandom_range(MIN_SIZE, 6);
				run_phase(CFG_DATA_W'(w_pick), CFG_DATA_W'(h_pick), $urandom_range(1, 2),
					$urandom_range(0, 2) == 0);
			end
			phase++;
		end

		sender_burst = 1'b0;
		drain_results();
		if (pending_medians.size() != 0) errors++;

		$display("Covered %0d pixel items and %0d median results over %0d frame ends.",
			pixels_sent, results_seen, frame_ends_seen);
		$display("Made %0d register writes (%0d mid-frame) and %0d long output holds.",
			cfg_writes, mid_frame_writes, long_holds);
		if (errors == 0) begin
			$display("median_filter_3x3_gray: match");
		end else begin
			$display("median_filter_3x3_gray: mismatch");
		end
		$finish;
	end

endmodule
